// ----- design/humidity_sensor_poll_sequencer_top_defines.svh -----
// Assertion macros shared by the sequencer RTL.
// All checks are clocked on clk and are disabled while rst_n is low.
`ifndef HUMIDITY_SENSOR_POLL_SEQUENCER_TOP_DEFINES_SVH
`define HUMIDITY_SENSOR_POLL_SEQUENCER_TOP_DEFINES_SVH

// A condition that must hold at every clock edge.
`define HSPS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition whose consequence must hold at the following clock edge.
`define HSPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/hsps_pkg.sv -----
`timescale 1ns / 1ps

package hsps_pkg;

    // Sequencer phases.
    typedef enum logic [3:0] {
        PH_INIT     = 4'd0,
        PH_FLUSH    = 4'd1,
        PH_RESET    = 4'd2,
        PH_RD_USER  = 4'd3,
        PH_WR_USER  = 4'd4,
        PH_RD_HEAT  = 4'd5,
        PH_WR_HEAT  = 4'd6,
        PH_MEASURE  = 4'd7,
        PH_RD_HUM   = 4'd8,
        PH_RD_TEMP  = 4'd9,
        PH_IDLE     = 4'd10
    } phase_t;

    // Kind of bus request issued by one poll.
    typedef enum logic [1:0] {
        REQ_NONE       = 2'd0,
        REQ_READ       = 2'd1,
        REQ_WRITE      = 2'd2,
        REQ_WRITE_READ = 2'd3
    } req_kind_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_I2C_ADDR      = 3'd0;
    localparam logic [2:0] CFG_DESIRED_USER  = 3'd1;
    localparam logic [2:0] CFG_DESIRED_HEAT  = 3'd2;
    localparam logic [2:0] CFG_POWER_ON_WAIT = 3'd3;
    localparam logic [2:0] CFG_RESET_WAIT    = 3'd4;
    localparam logic [2:0] CFG_CONV_WAIT     = 3'd5;

    localparam int unsigned WAIT_W = 31;
    localparam logic [WAIT_W-1:0] WAIT_RESET = 31'd25000000;

    // Sensor command bytes.
    localparam logic [7:0] CMD_NONE    = 8'h00;
    localparam logic [7:0] CMD_RESET   = 8'hFE;
    localparam logic [7:0] CMD_RD_USER = 8'hE7;
    localparam logic [7:0] CMD_WR_USER = 8'hE6;
    localparam logic [7:0] CMD_RD_HEAT = 8'h11;
    localparam logic [7:0] CMD_WR_HEAT = 8'h51;
    localparam logic [7:0] CMD_MEASURE = 8'hF5;
    localparam logic [7:0] CMD_RD_TEMP = 8'hE0;

    // Reserved bits kept from the value read back.
    localparam logic [7:0] USER_RSVD = 8'h3A;
    localparam logic [7:0] HEAT_RSVD = 8'hF0;

    // Status bits in the low two bits of a measurement word.
    localparam logic [1:0] HUM_STATUS  = 2'b10;
    localparam logic [1:0] TEMP_STATUS = 2'b00;

    // Read lengths.
    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_ONE  = 2'd1;
    localparam logic [1:0] LEN_TWO  = 2'd2;

    // Merge the wanted value with the reserved bits read from the sensor.
    function automatic logic [7:0] merge_rsvd(input logic [7:0] wanted,
                                              input logic [7:0] readback,
                                              input logic [7:0] rsvd);
        return (wanted & ~rsvd) | (readback & rsvd);
    endfunction

endpackage

// ----- design/humidity_sensor_poll_sequencer_top.sv -----
`timescale 1ns / 1ps

// Channel   | Signals                                         | Direction
// ----------+-------------------------------------------------+----------
// poll in   | in_valid, in_ready, bus_done, bus_error,        | input
//           | read_word, now_ticks                            |
// request   | out_valid, out_ready, request_kind, command_byte,| output
//           | write_byte, read_length, data_valid,            |
//           | humidity_raw, temperature_raw                   |
// config    | cfg_we, cfg_index, cfg_wdata                    | input
//
// One request per cycle sustained while out_ready holds: a poll is registered,
// the state step runs from the input register once the result register is
// free, and its result lands in the output register when the step is taken.
// Reset puts the sequencer in the init phase with the first-entry flag set.
// A stalled output holds the result register; the input register keeps
// accepting until it is also full, then in_ready drops.
module humidity_sensor_poll_sequencer_top
    import hsps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        bus_done,
    input  logic        bus_error,
    input  logic [15:0] read_word,
    input  logic [31:0] now_ticks,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  request_kind,
    output logic [7:0]  command_byte,
    output logic [7:0]  write_byte,
    output logic [1:0]  read_length,
    output logic        data_valid,
    output logic [15:0] humidity_raw,
    output logic [15:0] temperature_raw,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_wdata
);

`include "humidity_sensor_poll_sequencer_top_defines.svh"

    // Configuration registers.
    logic [7:0]        des_user_reg;
    logic [7:0]        des_heat_reg;
    logic [WAIT_W-1:0] power_wait_reg;
    logic [WAIT_W-1:0] reset_wait_reg;
    logic [WAIT_W-1:0] conv_wait_reg;

    // Input register.
    logic        s1_valid_reg;
    logic        s1_done_reg;
    logic        s1_err_reg;
    logic [15:0] s1_rd_reg;
    logic [31:0] s1_now_reg;

    // Sequencer state.
    phase_t      phase_reg, phase_next;
    logic        first_reg, first_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [7:0]  mrg_user_reg, mrg_user_next;
    logic [7:0]  mrg_heat_reg, mrg_heat_next;
    logic [15:0] hum_reg, hum_next;
    logic [15:0] temp_reg, temp_next;

    // Result register.
    logic        out_valid_reg;
    req_kind_t   kind_reg, kind_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  wbyte_reg, wbyte_next;
    logic [1:0]  len_reg, len_next;
    logic        dvalid_reg, dvalid_next;

    logic        step_go;
    logic [7:0]  rd_hi;
    logic [31:0] since_deadline;
    logic        time_reached;

    assign step_go  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || step_go;

    // Configuration writes; the bus address belongs to the bus master.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            des_user_reg   <= '0;
            des_heat_reg   <= '0;
            power_wait_reg <= WAIT_RESET;
            reset_wait_reg <= WAIT_RESET;
            conv_wait_reg  <= WAIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_I2C_ADDR:      ;
                CFG_DESIRED_USER:  des_user_reg   <= cfg_wdata[7:0];
                CFG_DESIRED_HEAT:  des_heat_reg   <= cfg_wdata[7:0];
                CFG_POWER_ON_WAIT: power_wait_reg <= cfg_wdata;
                CFG_RESET_WAIT:    reset_wait_reg <= cfg_wdata;
                CFG_CONV_WAIT:     conv_wait_reg  <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Input register load.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_done_reg <= bus_done;
            s1_err_reg  <= bus_error;
            s1_rd_reg   <= read_word;
            s1_now_reg  <= now_ticks;
        end
    end

    assign rd_hi          = s1_rd_reg[15:8];
    assign since_deadline = s1_now_reg - deadline_reg;
    assign time_reached   = !since_deadline[31];

    // One poll step: next phase, stored words and the bus request.
    always_comb
    begin
        phase_next    = phase_reg;
        first_next    = first_reg;
        deadline_next = deadline_reg;
        mrg_user_next = mrg_user_reg;
        mrg_heat_next = mrg_heat_reg;
        hum_next      = hum_reg;
        temp_next     = temp_reg;
        kind_next     = REQ_NONE;
        cmd_next      = CMD_NONE;
        wbyte_next    = CMD_NONE;
        len_next      = LEN_NONE;
        dvalid_next   = 1'b0;

        if (s1_done_reg)
        begin
            if (s1_err_reg)
            begin
                // A failed humidity read is retried in place; any other failure restarts at init.
                if (phase_reg != PH_RD_HUM)
                begin
                    phase_next = PH_INIT;
                end
                first_next = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_INIT:
                    begin
                        if (first_reg)
                            deadline_next = s1_now_reg + {1'b0, power_wait_reg};
                        else if (time_reached)
                            phase_next = PH_FLUSH;
                    end
                    PH_FLUSH:
                    begin
                        if (first_reg)
                        begin
                            kind_next = REQ_READ;
                            len_next  = LEN_TWO;
                        end
                        else
                        begin
                            phase_next = PH_RESET;
                        end
                    end
                    PH_RESET:
                    begin
                        if (first_reg)
                        begin
                            kind_next     = REQ_WRITE;
                            cmd_next      = CMD_RESET;
                            deadline_next = s1_now_reg + {1'b0, reset_wait_reg};
                        end
                        else if (time_reached)
                        begin
                            phase_next = PH_RD_USER;
                        end
                    end
                    PH_RD_USER:
                    begin
                        if (first_reg)
                        begin
                            kind_next = REQ_WRITE_READ;
                            cmd_next  = CMD_RD_USER;
                            len_next  = LEN_ONE;
                        end
                        else
                        begin
                            mrg_user_next = merge_rsvd(des_user_reg, rd_hi, USER_RSVD);
                            phase_next = (mrg_user_next != rd_hi) ? PH_WR_USER : PH_RD_HEAT;
                        end
                    end
                    PH_WR_USER:
                    begin
                        if (first_reg)
                        begin
                            kind_next  = REQ_WRITE;
                            cmd_next   = CMD_WR_USER;
                            wbyte_next = mrg_user_reg;
                        end
                        else
                        begin
                            phase_next = PH_RD_USER;
                        end
                    end
                    PH_RD_HEAT:
                    begin
                        if (first_reg)
                        begin
                            kind_next = REQ_WRITE_READ;
                            cmd_next  = CMD_RD_HEAT;
                            len_next  = LEN_ONE;
                        end
                        else
                        begin
                            mrg_heat_next = merge_rsvd(des_heat_reg, rd_hi, HEAT_RSVD);
                            phase_next = (mrg_heat_next != rd_hi) ? PH_WR_HEAT : PH_MEASURE;
                        end
                    end
                    PH_WR_HEAT:
                    begin
                        if (first_reg)
                        begin
                            kind_next  = REQ_WRITE;
                            cmd_next   = CMD_WR_HEAT;
                            wbyte_next = mrg_heat_reg;
                        end
                        else
                        begin
                            phase_next = PH_RD_HEAT;
                        end
                    end
                    PH_MEASURE:
                    begin
                        if (first_reg)
                        begin
                            kind_next = REQ_WRITE;
                            cmd_next  = CMD_MEASURE;
                        end
                        else
                        begin
                            deadline_next = s1_now_reg + {1'b0, conv_wait_reg};
                            phase_next    = PH_RD_HUM;
                        end
                    end
                    PH_RD_HUM:
                    begin
                        // Retry the read until the conversion deadline passes.
                        if (first_reg)
                        begin
                            if (!time_reached)
                            begin
                                kind_next = REQ_READ;
                                len_next  = LEN_TWO;
                            end
                            else
                            begin
                                phase_next = PH_RD_TEMP;
                            end
                        end
                        else
                        begin
                            hum_next   = s1_rd_reg;
                            phase_next = PH_RD_TEMP;
                        end
                    end
                    PH_RD_TEMP:
                    begin
                        if (first_reg)
                        begin
                            kind_next = REQ_WRITE_READ;
                            cmd_next  = CMD_RD_TEMP;
                            len_next  = LEN_TWO;
                        end
                        else
                        begin
                            temp_next  = s1_rd_reg;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_IDLE:
                    begin
                        phase_next = PH_RD_USER;
                    end
                    default:
                    begin
                        phase_next = PH_INIT;
                    end
                endcase

                first_next = (phase_next != phase_reg);
                dvalid_next = (phase_next == PH_IDLE) &&
                              (hum_next[1:0] == HUM_STATUS) &&
                              (temp_next[1:0] == TEMP_STATUS);
            end
        end
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_INIT;
            first_reg    <= 1'b1;
            deadline_reg <= '0;
            mrg_user_reg <= '0;
            mrg_heat_reg <= '0;
            hum_reg      <= '0;
            temp_reg     <= '0;
        end
        else if (step_go)
        begin
            phase_reg    <= phase_next;
            first_reg    <= first_next;
            deadline_reg <= deadline_next;
            mrg_user_reg <= mrg_user_next;
            mrg_heat_reg <= mrg_heat_next;
            hum_reg      <= hum_next;
            temp_reg     <= temp_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go)
        begin
            kind_reg   <= kind_next;
            cmd_reg    <= cmd_next;
            wbyte_reg  <= wbyte_next;
            len_reg    <= len_next;
            dvalid_reg <= dvalid_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign request_kind    = kind_reg;
    assign command_byte    = cmd_reg;
    assign write_byte      = wbyte_reg;
    assign read_length     = len_reg;
    assign data_valid      = dvalid_reg;
    assign humidity_raw    = hum_reg;
    assign temperature_raw = temp_reg;

    // A completed measurement never carries a new bus request.
    `HSPS_ASSERT_ALWAYS(a_valid_no_request,
        !(out_valid_reg && dvalid_reg) || (kind_reg == REQ_NONE),
        "data_valid reported together with a bus request")
    // An empty request must not carry stray bytes.
    `HSPS_ASSERT_ALWAYS(a_none_is_clean,
        !(out_valid_reg && kind_reg == REQ_NONE) ||
        (cmd_reg == CMD_NONE && wbyte_reg == CMD_NONE && len_reg == LEN_NONE),
        "empty request with nonzero request fields")
    // The input side only stalls when both registers are full and blocked.
    `HSPS_ASSERT_ALWAYS(a_stall_cause,
        in_ready || (s1_valid_reg && out_valid_reg && !out_ready),
        "input stalled without a full pipeline")
    // A poll held in the input register is not dropped while blocked.
    `HSPS_ASSERT_NEXT(a_hold_poll,
        s1_valid_reg && !step_go, s1_valid_reg && $stable(s1_now_reg),
        "blocked poll lost from the input register")
    // The idle phase is only ever reached for a single step.
    `HSPS_ASSERT_NEXT(a_idle_leaves,
        step_go && phase_reg == PH_IDLE && s1_done_reg && !s1_err_reg,
        phase_reg == PH_RD_USER,
        "idle phase did not return to the user register read")

endmodule
